@@ design/mtrp_pkg.sv @@
// Shared types and constants for the Modbus TCP response parser.
package mtrp_pkg;

  localparam int unsigned HEADER_BYTES = 6;
  localparam logic [7:0]  CODE_MASK    = 8'h7f;

  // Register indexes on the configuration channel
  localparam logic [1:0] REG_UNIT     = 2'd0;
  localparam logic [1:0] REG_FUNCTION = 2'd1;
  localparam logic [1:0] REG_LENGTH   = 2'd2;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_START,
    KIND_FAIL
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_UNIT,
    PH_FUNC,
    PH_COUNT,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNIT      = 3'd1,
    ST_FUNCTION  = 3'd2,
    ST_READFAIL  = 3'd3,
    ST_EXCEPTION = 3'd4
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] expected_unit;
    logic [6:0] expected_function;
    logic [7:0] fixed_length;
  } cfg_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] payload_byte;
    logic       done_res;
    status_t    status;
    logic [7:0] function_seen;
  } res_t;

endpackage

@@ design/mtrp_front.sv @@
// Input side: takes beats and tags each one as a byte, a frame start or a read failure.
module mtrp_front (
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic [1:0]         in_tuser,
  output logic               push,
  output mtrp_pkg::item_t    push_item,
  input  logic               queue_ready
);

  assign in_tready = queue_ready;
  assign push      = in_tvalid && queue_ready;

  // operation (tuser[0]) wins over frame_start (tuser[1])
  always_comb begin
    push_item.data = in_tdata;
    if (in_tuser[0]) begin
      push_item.kind = mtrp_pkg::KIND_FAIL;
    end else if (in_tuser[1]) begin
      push_item.kind = mtrp_pkg::KIND_START;
    end else begin
      push_item.kind = mtrp_pkg::KIND_BYTE;
    end
  end

endmodule

@@ design/mtrp_fifo.sv @@
// Short queue of classified items between the input side and the parser.
module mtrp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mtrp_pkg::item_t  push_item,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output mtrp_pkg::item_t  pop_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  mtrp_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ design/mtrp_back.sv @@
// Parser state machine: walks header, unit, function, count and payload; drives the result register.
module mtrp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mtrp_pkg::cfg_t   cfg,
  input  logic             item_valid,
  input  mtrp_pkg::item_t  item,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_ready,
  output mtrp_pkg::res_t   res
);

  mtrp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]       left_r, left_nxt;
  logic [7:0]       func_r, func_nxt;
  logic             res_valid_r, res_valid_nxt;
  mtrp_pkg::res_t   res_r, res_nxt;
  logic             fire;
  logic             emit_dv;
  logic [7:0]       emit_byte;
  logic             emit_done;
  mtrp_pkg::status_t emit_st;

  assign pop       = item_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    left_nxt    = left_r;
    func_nxt    = func_r;
    fire        = 1'b0;
    emit_dv     = 1'b0;
    emit_byte   = '0;
    emit_done   = 1'b0;
    emit_st     = mtrp_pkg::ST_OK;
    if (pop) begin
      case (item.kind)
        mtrp_pkg::KIND_FAIL: begin
          if (phase_r != mtrp_pkg::PH_IDLE) begin
            phase_nxt = mtrp_pkg::PH_IDLE;
            fire      = 1'b1;
            emit_done = 1'b1;
            emit_st   = mtrp_pkg::ST_READFAIL;
          end
        end
        mtrp_pkg::KIND_START: begin
          func_nxt    = '0;
          left_nxt    = '0;
          hdr_cnt_nxt = 3'd1;
          phase_nxt   = mtrp_pkg::PH_HEADER;
        end
        mtrp_pkg::KIND_BYTE: begin
          case (phase_r)
            mtrp_pkg::PH_HEADER: begin
              hdr_cnt_nxt = hdr_cnt_r + 3'd1;
              if (hdr_cnt_nxt >= 3'(mtrp_pkg::HEADER_BYTES)) begin
                phase_nxt = mtrp_pkg::PH_UNIT;
              end
            end
            mtrp_pkg::PH_UNIT: begin
              if (item.data != cfg.expected_unit) begin
                phase_nxt = mtrp_pkg::PH_IDLE;
                fire      = 1'b1;
                emit_done = 1'b1;
                emit_st   = mtrp_pkg::ST_UNIT;
              end else begin
                phase_nxt = mtrp_pkg::PH_FUNC;
              end
            end
            mtrp_pkg::PH_FUNC: begin
              func_nxt = item.data;
              // exception frames must still echo the code in the low bits
              if ((item.data & mtrp_pkg::CODE_MASK) != {1'b0, cfg.expected_function}) begin
                phase_nxt = mtrp_pkg::PH_IDLE;
                fire      = 1'b1;
                emit_done = 1'b1;
                emit_st   = mtrp_pkg::ST_FUNCTION;
              end else if (item.data[7]) begin
                left_nxt  = 8'd1;
                phase_nxt = mtrp_pkg::PH_DATA;
              end else if (cfg.fixed_length != '0) begin
                left_nxt  = cfg.fixed_length;
                phase_nxt = mtrp_pkg::PH_DATA;
              end else begin
                phase_nxt = mtrp_pkg::PH_COUNT;
              end
            end
            mtrp_pkg::PH_COUNT: begin
              left_nxt  = item.data;
              fire      = 1'b1;
              emit_dv   = 1'b1;
              emit_byte = item.data;
              if (item.data == '0) begin
                phase_nxt = mtrp_pkg::PH_IDLE;
                emit_done = 1'b1;
              end else begin
                phase_nxt = mtrp_pkg::PH_DATA;
              end
            end
            mtrp_pkg::PH_DATA: begin
              fire      = 1'b1;
              emit_dv   = 1'b1;
              emit_byte = item.data;
              if (left_r <= 8'd1) begin
                left_nxt  = '0;
                phase_nxt = mtrp_pkg::PH_IDLE;
                emit_done = 1'b1;
                emit_st   = func_r[7] ? mtrp_pkg::ST_EXCEPTION : mtrp_pkg::ST_OK;
              end else begin
                left_nxt = left_r - 8'd1;
              end
            end
            default: begin
              // idle: stray bytes are dropped until a frame start
              phase_nxt = mtrp_pkg::PH_IDLE;
            end
          endcase
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    res_nxt.data_valid    = emit_dv;
    res_nxt.payload_byte  = emit_byte;
    res_nxt.done_res      = emit_done;
    res_nxt.status        = emit_st;
    res_nxt.function_seen = func_nxt;

    if (res_valid_r && !res_ready) begin
      res_valid_nxt = 1'b1;
    end else begin
      res_valid_nxt = pop && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mtrp_pkg::PH_IDLE;
      hdr_cnt_r   <= '0;
      left_r      <= '0;
      func_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      left_r      <= left_nxt;
      func_r      <= func_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ design/modbus_tcp_response_parser.sv @@
// Modbus TCP response parser: one received byte per beat in, payload bytes and status out.
//
// Input channel (in_*): one beat per received byte. in_tuser[0] flags a link read
// failure, in_tuser[1] marks the first header byte of a new response.
// Output channel (out_*): one beat per count, data or exception byte, and one beat
// for a frame that ends in error. out_tlast marks the final beat of a response and
// carries its status; out_tuser is set when out_tdata holds a payload byte.
// Configuration channel (cfg_*): index 0 expected unit, 1 expected function,
// 2 fixed length (zero selects a byte-count byte). Write only while idle; other
// indexes are ignored. cfg_ready is always high.
// Throughput: one beat per cycle on both sides while out_tready stays high. An
// accepted input beat enters the item queue, and the parser step then pops it and
// loads the output register; a stalled output register or earlier queued items
// keep it waiting in the queue.
// When the receiver stalls, the output register holds and the queue
// (FIFO_DEPTH entries) absorbs input before in_tready drops.
// Reset returns the parser to idle, empties the queue and clears out_tvalid;
// registers return to unit 0, function 3, fixed length 0.
module modbus_tcp_response_parser #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [0] operation, [1] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] payload_byte, [10:8] status, [18:11] function_seen
  output logic        out_tuser,  // [0] data_valid
  output logic        out_tlast,  // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  mtrp_pkg::cfg_t  cfg_r;
  mtrp_pkg::item_t push_item;
  mtrp_pkg::item_t pop_item;
  mtrp_pkg::res_t  res;
  logic            push;
  logic            push_ready;
  logic            pop;
  logic            pop_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_unit     <= 8'd0;
      cfg_r.expected_function <= 7'd3;
      cfg_r.fixed_length      <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mtrp_pkg::REG_UNIT:     cfg_r.expected_unit     <= cfg_data;
        mtrp_pkg::REG_FUNCTION: cfg_r.expected_function <= cfg_data[6:0];
        mtrp_pkg::REG_LENGTH:   cfg_r.fixed_length      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mtrp_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .push        (push),
    .push_item   (push_item),
    .queue_ready (push_ready)
  );

  mtrp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  mtrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (pop_valid),
    .item       (pop_item),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {5'd0, res.function_seen, res.status, res.payload_byte};
  assign out_tuser = res.data_valid;
  assign out_tlast = res.done_res;

endmodule

@@ design/mtrp_checker.sv @@
// Port-level checks on the parser's result channel, bound to the top level.
module mtrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // a beat without payload only ever reports the end of a frame
  a_nodata_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[7:0] == 8'd0)
    else $error("beat carries neither data nor completion");

  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[10:8] == 3'd0)
    else $error("status reported before end of frame");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[10] || out_tdata[9:8] == 2'd0)
    else $error("status code out of range");

endmodule

bind modbus_tcp_response_parser mtrp_checker u_mtrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
